// File: design/utf8_stream_decoder_unit_defines.svh
// Assertion macros shared by the UTF-8 stream decoder RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef UTF8_STREAM_DECODER_UNIT_DEFINES_SVH
`define UTF8_STREAM_DECODER_UNIT_DEFINES_SVH

// Checked only outside reset.
`define U8SD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define U8SD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/u8sd_pkg.sv
// Types, constants and decode functions of the UTF-8 stream decoder.
// Used by the top level and by the testbench; depends on nothing.
package u8sd_pkg;

   localparam int unsigned BufDepth = 4;

   localparam logic [20:0] QMark     = 21'h00003F;
   localparam logic [20:0] MinTwo    = 21'h000080;
   localparam logic [20:0] MinThree  = 21'h000800;
   localparam logic [20:0] MinFour   = 21'h010000;

   typedef logic [BufDepth-1:0][7:0] byte_buf_type;

   // Outcome of looking at the head of the byte buffer.
   typedef struct packed {
      logic        brk;    // head sequence is still open, nothing to emit
      logic [20:0] cp;
      logic [2:0]  cnt;
      logic        rep;
      logic [2:0]  take;   // bytes removed from the head
   } head_result_type;

   function automatic logic [2:0] lead_len(input logic [7:0] b);
      logic [2:0] n;
      n = 3'd0;
      if (b[7] == 1'b0)            n = 3'd1;
      else if (b[7:5] == 3'b110)   n = 3'd2;
      else if (b[7:4] == 4'b1110)  n = 3'd3;
      else if (b[7:3] == 5'b11110) n = 3'd4;
      return n;
   endfunction

   function automatic logic is_cont(input logic [7:0] b);
      return b[7:6] == 2'b10;
   endfunction

   function automatic head_result_type decode_head(input byte_buf_type bb,
                                                   input logic [2:0]   len,
                                                   input logic         eot);
      head_result_type r;
      logic [2:0]  need;
      logic        bad;
      logic [20:0] cp;
      logic [20:0] minv;
      need   = lead_len(bb[0]);
      r.brk  = 1'b0;
      r.cp   = QMark;
      r.cnt  = 3'd1;
      r.rep  = 1'b1;
      r.take = 3'd1;
      bad = (need >= 3'd2 && len >= 3'd2 && !is_cont(bb[1]))
         || (need >= 3'd3 && len >= 3'd3 && !is_cont(bb[2]))
         || (need == 3'd4 && len == 3'd4 && !is_cont(bb[3]));
      unique case (need)
         3'd2: begin
            cp   = {10'd0, bb[0][4:0], bb[1][5:0]};
            minv = MinTwo;
         end
         3'd3: begin
            cp   = {5'd0, bb[0][3:0], bb[1][5:0], bb[2][5:0]};
            minv = MinThree;
         end
         3'd4: begin
            cp   = {bb[0][2:0], bb[1][5:0], bb[2][5:0], bb[3][5:0]};
            minv = MinFour;
         end
         default: begin
            cp   = {13'd0, bb[0]};
            minv = 21'd0;
         end
      endcase
      if (need == 3'd1) begin
         r.cp  = cp;
         r.rep = 1'b0;
      end else if (need != 3'd0 && !bad) begin
         if (len < need) begin
            r.brk = !eot;
         end else if (cp >= minv) begin
            r.cp   = cp;
            r.cnt  = need;
            r.rep  = 1'b0;
            r.take = need;
         end
      end
      return r;
   endfunction

   // Drops take bytes from the head of the buffer.
   function automatic byte_buf_type shift_buf(input byte_buf_type bb,
                                              input logic [2:0]   take);
      byte_buf_type o;
      logic [2:0]   idx;
      for (int i = 0; i < BufDepth; i++) begin
         idx = 3'(i) + take;
         o[i] = (idx < 3'(BufDepth)) ? bb[idx[1:0]] : 8'd0;
      end
      return o;
   endfunction

endpackage

// File: design/u8sd_channels.sv
// Valid/ready channel interfaces of the UTF-8 stream decoder.
// Depends on nothing but plain logic types.
interface u8sd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_text;
   modport source (output valid, data_byte, end_of_text, input ready);
   modport sink   (input valid, data_byte, end_of_text, output ready);
endinterface

interface u8sd_rsp_if;
   logic        valid;
   logic        ready;
   logic [20:0] code_point;
   logic [2:0]  consumed_bytes;
   logic        replaced;
   logic        last;
   modport source (output valid, code_point, consumed_bytes, replaced, last,
                   input ready);
   modport sink   (input valid, code_point, consumed_bytes, replaced, last,
                   output ready);
endinterface

// File: design/utf8_stream_decoder_unit.sv
// UTF-8 stream decoder, top level.
// Depends on u8sd_pkg, the channel interfaces and the assertion macro header.
//
// Usage: raw text bytes enter on the req channel, one byte per transfer, with
// end_of_text set on the final byte of a text. Decoded code points leave on
// the rsp channel, each with the number of bytes it stands for. Invalid lead
// bytes, broken or overlong sequences and sequences cut off by end_of_text
// come out as '?' with replaced set, and the bytes behind them are decoded
// again. The last result caused by one input byte carries last.
// Timing: an accepted byte is registered in the working buffer, and its first
// result is registered in the output register from there. The head decoder
// produces the results one by one, so a byte that causes several results
// holds the req side off until its last result is produced; plain text runs
// at one byte per cycle while the output does not stall. A byte that only
// extends an open sequence produces no transfer and needs no output slot.
// Stalls: while the receiver holds rsp ready low, the result waits in the
// output register and the req side stalls once the buffer has work for it.
// Reset clears the open sequence and drops any result not yet transferred.
`include "utf8_stream_decoder_unit_defines.svh"

module utf8_stream_decoder_unit (
   input logic               clock,
   input logic               reset,
   u8sd_req_if.sink          req_if,
   u8sd_rsp_if.source        rsp_if
);

   // Working buffer: held bytes of an open sequence plus the newest byte.
   u8sd_pkg::byte_buf_type buf_ff, buf_in;
   logic [2:0]             len_ff, len_in;
   logic                   end_ff, end_in;
   logic                   active_ff, active_in;

   // Output register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [20:0]            cp_ff, cp_in;
   logic [2:0]             cnt_ff, cnt_in;
   logic                   rep_ff, rep_in;
   logic                   last_ff, last_in;

   u8sd_pkg::head_result_type step, nxt;
   u8sd_pkg::byte_buf_type    rem_buf, base_buf;
   logic [2:0]                take_eff, rem_len, base_len;
   logic                      finish, step_go, emit, req_ready, accept;

   // Decode the head of the buffer, then look one step ahead on what remains
   // to know whether this result is the last one for the current byte.
   always_comb begin
      step     = u8sd_pkg::decode_head(buf_ff, len_ff, end_ff);
      take_eff = step.brk ? 3'd0 : step.take;
      rem_buf  = u8sd_pkg::shift_buf(buf_ff, take_eff);
      rem_len  = len_ff - take_eff;
      nxt      = u8sd_pkg::decode_head(rem_buf, rem_len, end_ff);
      finish   = step.brk || (rem_len == 3'd0) || nxt.brk;
      // An open sequence needs no output slot, a result does.
      step_go  = active_ff && (step.brk || !rsp_valid_ff || rsp_if.ready);
      emit     = step_go && !step.brk;
      req_ready = !active_ff || (step_go && finish);
      accept   = req_if.valid && req_ready;
      base_buf = active_ff ? rem_buf : buf_ff;
      base_len = active_ff ? rem_len : len_ff;
   end

   assign req_if.ready = req_ready;

   always_comb begin
      buf_in    = buf_ff;
      len_in    = len_ff;
      end_in    = end_ff;
      active_in = active_ff;
      if (accept) begin
         // What remains never exceeds three bytes, so the new byte fits.
         buf_in                = base_buf;
         buf_in[base_len[1:0]] = req_if.data_byte;
         len_in                = base_len + 3'd1;
         end_in                = req_if.end_of_text;
         active_in             = 1'b1;
      end else if (step_go) begin
         buf_in    = rem_buf;
         len_in    = rem_len;
         active_in = !finish;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      cp_in        = cp_ff;
      cnt_in       = cnt_ff;
      rep_in       = rep_ff;
      last_in      = last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         cp_in        = step.cp;
         cnt_in       = step.cnt;
         rep_in       = step.rep;
         last_in      = finish;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= 3'd0;
         end_ff       <= 1'b0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         end_ff       <= end_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff  <= buf_in;
      cp_ff   <= cp_in;
      cnt_ff  <= cnt_in;
      rep_ff  <= rep_in;
      last_ff <= last_in;
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.code_point     = cp_ff;
   assign rsp_if.consumed_bytes = cnt_ff;
   assign rsp_if.replaced       = rep_ff;
   assign rsp_if.last           = last_ff;

   // Reset empties both the working buffer and the output register.
   `U8SD_ASSERT_ALWAYS(a_reset_clears, clock,
      reset |=> (!active_ff && !rsp_valid_ff), "reset did not clear the decoder")
   // A byte under work always leaves something in the buffer.
   `U8SD_ASSERT(a_active_has_bytes, clock, reset,
      active_ff |-> (len_ff != 3'd0 && len_ff <= 3'd4), "active buffer with bad length")
   // Between bytes at most three bytes of an open sequence are held.
   `U8SD_ASSERT(a_pending_bound, clock, reset,
      !active_ff |-> (len_ff <= 3'd3), "too many held bytes")
   // Finishing a final byte leaves nothing held.
   `U8SD_ASSERT(a_flush_at_end, clock, reset,
      (step_go && finish && end_ff && !accept) |=> (len_ff == 3'd0),
      "bytes held after end of text")
   // A replacement always stands for one byte and reads as a question mark.
   `U8SD_ASSERT(a_replace_form, clock, reset,
      (rsp_valid_ff && rep_ff) |-> (cp_ff == u8sd_pkg::QMark && cnt_ff == 3'd1),
      "malformed replacement result")

endmodule

// File: tb/sv/u8sd_tb_pkg.sv
// Scoreboard for the UTF-8 stream decoder testbench: a byte-level decoder that
// predicts every result and a queue of the results still awaited.
// Depends on u8sd_pkg for the replacement character and the overlong limits.
package u8sd_tb_pkg;

   localparam int unsigned MaxReports = 10;

   typedef struct packed {
      logic [20:0] code_point;
      logic [2:0]  consumed_bytes;
      logic        replaced;
      logic        last;
   } decoded_char_type;

   class utf8_char_scoreboard;

      logic [7:0]       held_bytes [3];
      int unsigned      held_count;
      decoded_char_type awaited_chars [$];
      int unsigned      failures;

      function new();
         held_count = 0;
         failures   = 0;
         foreach (held_bytes[i]) held_bytes[i] = 8'h00;
      endfunction

      // Length of the sequence that a lead byte opens, 0 for an invalid lead.
      static function int unsigned lead_span(logic [7:0] b);
         if (b[7] == 1'b0)            return 1;
         if (b[7:5] == 3'b110)        return 2;
         if (b[7:4] == 4'b1110)       return 3;
         if (b[7:3] == 5'b11110)      return 4;
         return 0;
      endfunction

      function void push_char(logic [20:0] cp, logic [2:0] cnt, logic rep);
         decoded_char_type c;
         c.code_point     = cp;
         c.consumed_bytes = cnt;
         c.replaced       = rep;
         c.last           = 1'b0;
         awaited_chars.push_back(c);
      endfunction

      // Appends the byte to the held sequence and decodes from the head until
      // the buffer is empty or an open sequence has to wait for more bytes.
      function void decode_byte(logic [7:0] data_byte, logic end_of_text);
         logic [7:0]  work [4];
         int unsigned len;
         int unsigned need;
         int unsigned take;
         int unsigned avail;
         int unsigned first_idx;
         logic        broken;
         logic        waiting;
         logic [20:0] value;
         logic [20:0] lowest;
         first_idx = awaited_chars.size();
         len       = 0;
         waiting   = 1'b0;
         for (int i = 0; i < held_count; i++) begin
            work[len] = held_bytes[i];
            len++;
         end
         work[len] = data_byte;
         len++;
         while (len > 0 && !waiting) begin
            need = lead_span(work[0]);
            take = 1;
            if (need == 0) begin
               push_char(u8sd_pkg::QMark, 3'd1, 1'b1);
            end else if (need == 1) begin
               push_char({13'd0, work[0]}, 3'd1, 1'b0);
            end else begin
               avail  = (len < need) ? len : need;
               broken = 1'b0;
               for (int k = 1; k < avail; k++) begin
                  if (work[k][7:6] != 2'b10) broken = 1'b1;
               end
               if (broken) begin
                  push_char(u8sd_pkg::QMark, 3'd1, 1'b1);
               end else if (len < need) begin
                  if (end_of_text) push_char(u8sd_pkg::QMark, 3'd1, 1'b1);
                  else waiting = 1'b1;
               end else begin
                  case (need)
                     2: begin
                        value  = {10'd0, work[0][4:0], work[1][5:0]};
                        lowest = u8sd_pkg::MinTwo;
                     end
                     3: begin
                        value  = {5'd0, work[0][3:0], work[1][5:0], work[2][5:0]};
                        lowest = u8sd_pkg::MinThree;
                     end
                     default: begin
                        value  = {work[0][2:0], work[1][5:0], work[2][5:0], work[3][5:0]};
                        lowest = u8sd_pkg::MinFour;
                     end
                  endcase
                  if (value < lowest) begin
                     push_char(u8sd_pkg::QMark, 3'd1, 1'b1);
                  end else begin
                     push_char(value, 3'(need), 1'b0);
                     take = need;
                  end
               end
            end
            if (!waiting) begin
               for (int i = 0; i + take < len; i++) work[i] = work[i + take];
               len -= take;
            end
         end
         foreach (held_bytes[i]) held_bytes[i] = 8'h00;
         held_count = len;
         for (int i = 0; i < len; i++) held_bytes[i] = work[i];
         if (awaited_chars.size() > first_idx)
            awaited_chars[awaited_chars.size() - 1].last = 1'b1;
      endfunction

      function void check_char(logic [20:0] cp, logic [2:0] cnt, logic rep, logic lst);
         decoded_char_type want;
         if (awaited_chars.size() == 0) begin
            failures++;
            if (failures <= MaxReports)
               $display("unexpected result: code_point %h consumed %0d replaced %0b last %0b",
                        cp, cnt, rep, lst);
            return;
         end
         want = awaited_chars.pop_front();
         if (want.code_point !== cp || want.consumed_bytes !== cnt ||
             want.replaced !== rep || want.last !== lst) begin
            failures++;
            if (failures <= MaxReports)
               $display("result mismatch: expected %h/%0d/%0b/%0b, got %h/%0d/%0b/%0b",
                        want.code_point, want.consumed_bytes, want.replaced, want.last,
                        cp, cnt, rep, lst);
         end
      endfunction

      // Counts results that never arrived and returns the total failure count.
      function int unsigned close_out();
         failures += awaited_chars.size();
         return failures;
      endfunction

   endclass

endpackage

// File: tb/sv/utf8_stream_decoder_unit_tb.sv
// Top level of the UTF-8 stream decoder testbench: clock, reset, byte sender,
// result receiver and monitor. Depends on u8sd_pkg, the channel interfaces,
// u8sd_tb_pkg and the decoder top level.
module utf8_stream_decoder_unit_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned HalfPeriod     = 5;
   localparam int unsigned ResetCycles    = 4;
   localparam int unsigned DirectedCount  = 25;
   localparam int unsigned RandomBytes    = 305;
   localparam int unsigned TotalBytes     = DirectedCount + RandomBytes;
   localparam int unsigned QuietFrom      = TotalBytes - 40;
   localparam int unsigned HoldOffCycles  = 64;
   localparam int unsigned DrainCycles    = 16;
   localparam int unsigned TimeLimitNs    = 2_000_000;

   // Directed bytes as {end_of_text, data_byte}. They walk through the field
   // extremes and these special cases: plain ASCII at both ends of its range,
   // the smallest two- and three-byte values, the largest four-byte value,
   // stray continuation bytes and leads 0xF8 and 0xFF, a broken continuation,
   // overlong two- and four-byte forms, and a four-byte sequence cut short by
   // end_of_text.
   localparam logic [8:0] DirectedBytes [DirectedCount] = '{
      9'h000, 9'h17F,
      9'h0C2, 9'h080,
      9'h0E0, 9'h0A0, 9'h080,
      9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,
      9'h080, 9'h0F8, 9'h0FF,
      9'h0E2, 9'h041,
      9'h0C0, 9'h080,
      9'h0F0, 9'h08F, 9'h0BF, 9'h0BF,
      9'h0F0, 9'h090, 9'h180
   };

   logic clock;
   logic reset;

   u8sd_req_if req_ch();
   u8sd_rsp_if rsp_ch();

   utf8_stream_decoder_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   u8sd_tb_pkg::utf8_char_scoreboard char_board = new();

   // When quiet is set, neither side inserts idle cycles any more.
   logic        quiet = 1'b0;
   // The stimulus raises this flag to ask the receiver for one long hold-off.
   logic        hold_off_req = 1'b0;
   int unsigned bytes_sent = 0;

   initial begin
      clock = 1'b0;
      forever #HalfPeriod clock = ~clock;
   end

   // Hard limit on the run, far above the slowest correct run.
   initial begin
      #TimeLimitNs;
      $display("simulation failed");
      $finish;
   end

   // The monitor samples both channels at the rising edge. A byte transfer is
   // decoded by the scoreboard, and a result transfer is checked against the
   // oldest awaited result. A result can never come out in the same cycle as
   // the byte that causes it, so the order of the two calls does not matter.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            char_board.decode_byte(req_ch.data_byte, req_ch.end_of_text);
         if (rsp_ch.valid && rsp_ch.ready)
            char_board.check_char(rsp_ch.code_point, rsp_ch.consumed_bytes,
                                  rsp_ch.replaced, rsp_ch.last);
      end
   end

   // Receiver. Ready changes only at the falling edge. It normally stays high,
   // drops for random bursts, and once holds off for a long stretch so that
   // the decoder fills up and stalls the byte side.
   initial begin
      int unsigned gap;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_ch.ready = 1'b0;
            repeat (HoldOffCycles - 1) @(negedge clock);
            hold_off_req = 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 6);
            rsp_ch.ready = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end else begin
            rsp_ch.ready = 1'b1;
         end
      end
   end

   // Offers one byte at a falling edge and holds it until the rising edge at
   // which the transfer takes place. A random idle burst may come first.
   task automatic send_byte(input logic [7:0] b, input logic eot);
      int unsigned gap;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 6);
         @(negedge clock);
         req_ch.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid       = 1'b1;
      req_ch.data_byte   = b;
      req_ch.end_of_text = eot;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      bytes_sent++;
   endtask

   // Encodes a value in the given number of bytes without checking that the
   // value fits the shortest form, so that overlong forms can be built too.
   function automatic logic [3:0][7:0] encode_utf8(logic [20:0] cp, int unsigned span);
      logic [3:0][7:0] seq;
      seq = '0;
      case (span)
         1: seq[0] = {1'b0, cp[6:0]};
         2: begin
            seq[0] = {3'b110, cp[10:6]};
            seq[1] = {2'b10, cp[5:0]};
         end
         3: begin
            seq[0] = {4'b1110, cp[15:12]};
            seq[1] = {2'b10, cp[11:6]};
            seq[2] = {2'b10, cp[5:0]};
         end
         default: begin
            seq[0] = {5'b11110, cp[20:18]};
            seq[1] = {2'b10, cp[17:12]};
            seq[2] = {2'b10, cp[11:6]};
            seq[3] = {2'b10, cp[5:0]};
         end
      endcase
      return seq;
   endfunction

   // Random value that is valid in the shortest form of the given span.
   function automatic logic [20:0] random_value(int unsigned span);
      case (span)
         1:       return 21'($urandom_range(0, 'h7F));
         2:       return 21'($urandom_range('h80, 'h7FF));
         3:       return 21'($urandom_range('h800, 'hFFFF));
         default: return 21'($urandom_range('h10000, 'h1FFFFF));
      endcase
   endfunction

   // Picks one character of random text. Most are well-formed code points of
   // every length; the rest are noise bytes, sequences cut short (which the
   // next character then breaks) and overlong forms.
   task automatic pick_char(output logic [3:0][7:0] seq, output int unsigned n);
      int unsigned roll;
      int unsigned span;
      logic [20:0] cp;
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
         n   = 1;
         seq = encode_utf8(random_value(1), 1);
      end else if (roll < 76) begin
         span = (roll < 48) ? 2 : (roll < 63) ? 3 : 4;
         n    = span;
         seq  = encode_utf8(random_value(span), span);
      end else if (roll < 84) begin
         n      = 1;
         seq    = '0;
         seq[0] = 8'($urandom_range(0, 255));
      end else if (roll < 92) begin
         span = $urandom_range(2, 4);
         n    = $urandom_range(1, span - 1);
         seq  = encode_utf8(random_value(span), span);
      end else begin
         // Overlong: a value that would fit in one byte fewer.
         span = $urandom_range(2, 4);
         cp   = random_value(span - 1);
         if ($urandom_range(0, 3) == 0) cp = 21'($urandom_range(0, 'h7F));
         n    = span;
         seq  = encode_utf8(cp, span);
      end
   endtask

   initial begin
      logic [3:0][7:0] seq;
      int unsigned     n;
      int unsigned     text_len;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.data_byte   = 8'h00;
      req_ch.end_of_text = 1'b0;
      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (DirectedBytes[i])
         send_byte(DirectedBytes[i][7:0], DirectedBytes[i][8]);

      // The long hold-off starts while random bytes keep coming.
      hold_off_req = 1'b1;

      // Random texts of one to twelve characters. The final byte of each text
      // carries end_of_text, which also cuts short any sequence left open.
      while (bytes_sent < TotalBytes) begin
         text_len = $urandom_range(1, 12);
         for (int c = 0; c < text_len; c++) begin
            pick_char(seq, n);
            for (int j = 0; j < n; j++) begin
               if (bytes_sent >= QuietFrom) quiet = 1'b1;
               send_byte(seq[j], (c == text_len - 1) && (j == n - 1));
            end
         end
      end

      @(negedge clock);
      req_ch.valid = 1'b0;

      // Wait for every awaited result, then for DrainCycles more clock edges so
      // that a stray extra result would still be seen by the monitor.
      while (char_board.awaited_chars.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (char_board.close_out() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
